FILE: hdl/ptopo_pkg.sv
// Shared types and constants for the priority topological ordering block.
package ptopo_pkg;

    localparam int PRIO_W = 16;
    localparam int FIELD_W = 6;
    localparam int CNT_W = 7;
    localparam int MODE_W = 2;

    localparam logic [MODE_W-1:0] MODE_PRIO = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EDGE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RUN  = 2'd2;

    typedef struct packed {
        logic clear;
        logic sample;
    } t_scan_ctl;

endpackage

FILE: hdl/ptopo_min_unit.sv
// Shared least-priority tracker used by every node scan.
module ptopo_min_unit #(
    parameter int NW = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ptopo_pkg::t_scan_ctl  i_ctl,
    input  logic [NW-1:0]         i_idx,
    input  logic [15:0]           i_prio,
    output logic                  o_vld,
    output logic [NW-1:0]         o_idx
);
    import ptopo_pkg::*;

    logic              r_vld;
    logic [NW-1:0]     r_idx;
    logic [PRIO_W-1:0] r_prio;
    logic              w_take;

    // strict less keeps the lower index on ties
    assign w_take = i_ctl.sample && (!r_vld || (i_prio < r_prio));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.clear) begin
            r_vld <= 1'b0;
        end else if (w_take) begin
            r_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_idx  <= i_idx;
            r_prio <= i_prio;
        end
    end

    assign o_vld = r_vld;
    assign o_idx = r_idx;

endmodule

FILE: hdl/priority_topological_order.sv
// Top level: priority-driven topological ordering of a loaded node graph.
//
// Items enter on start while busy is low. Mode 0 loads one node priority and
// mode 1 appends one edge (higher above lower); both leave busy low. Mode 2
// runs the ordering over node_count nodes (set through i_cfg_we /
// i_cfg_wdata while idle, capped at MAX_NODES) and raises busy until it is finished.
// Each emitted node appears for one cycle with o_valid; o_last marks the
// final one. The receiver cannot stall, so results are never held back.
// A run clears the node state, counts in-degrees over the stored edges, then
// for each position scans the nodes, picks the least-priority ready one and
// walks the edges to decrement its successors (skipped in fallback). When no
// node is ready the graph has a cycle: the scan repeats in fallback, which
// orders the rest by priority alone. The edge store is released at the end.
// The per-node scan and per-edge walk share one read port per memory; the
// scan feeds a single least-priority tracker. A run with node_count zero
// emits nothing and only clears the edge store.
// Reset clears node_count, the edge store and all priorities to zero.
module priority_topological_order #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [ptopo_pkg::MODE_W-1:0]         i_mode,
    input  logic [ptopo_pkg::FIELD_W-1:0]        i_node_index,
    input  logic [ptopo_pkg::PRIO_W-1:0]         i_priority_req,
    input  logic [ptopo_pkg::FIELD_W-1:0]        i_edge_higher,
    input  logic [ptopo_pkg::FIELD_W-1:0]        i_edge_lower,
    input  logic                                 i_cfg_we,
    input  logic [ptopo_pkg::CNT_W-1:0]          i_cfg_wdata,
    output logic                                 o_valid,
    output logic [ptopo_pkg::FIELD_W-1:0]        o_out_node,
    output logic [ptopo_pkg::FIELD_W-1:0]        o_new_priority,
    output logic                                 o_last
);
    import ptopo_pkg::*;

    localparam int NW  = $clog2(MAX_NODES);
    localparam int CW  = (NW + 1 > CNT_W) ? NW + 1 : CNT_W;
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int SW  = EW + 1;
    localparam int EDW = 2 * FIELD_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLR    = 4'd1;
    localparam logic [3:0] S_IN_RD  = 4'd2;
    localparam logic [3:0] S_IN_ST  = 4'd3;
    localparam logic [3:0] S_IN_WR  = 4'd4;
    localparam logic [3:0] S_SCAN   = 4'd5;
    localparam logic [3:0] S_PICK   = 4'd6;
    localparam logic [3:0] S_DEC_RD = 4'd7;
    localparam logic [3:0] S_DEC_ST = 4'd8;
    localparam logic [3:0] S_DEC_WR = 4'd9;
    localparam logic [3:0] S_NEXT   = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    // memories
    logic [PRIO_W-1:0]    r_prio_mem [MAX_NODES];
    logic [SW-1:0]        r_st_mem   [MAX_NODES];
    logic [EDW-1:0]       r_edge_mem [MAX_EDGES];
    logic [MAX_NODES-1:0] r_pvld;
    logic [PRIO_W-1:0]    r_prio_q;
    logic                 r_pvld_q;
    logic [SW-1:0]        r_st_q;
    logic [EDW-1:0]       r_edge_q;

    // control
    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CW-1:0]    r_n, n_n;
    logic [CW-1:0]    r_v, n_v;
    logic [CW-1:0]    r_pos, n_pos;
    logic [EW-1:0]    r_e, n_e;
    logic [EW-1:0]    r_etot, n_etot;
    logic             r_fb, n_fb;
    logic             r_rd_vld, n_rd_vld;
    logic [NW-1:0]    r_rd_idx, n_rd_idx;
    logic             r_ovld, n_ovld;
    logic [FIELD_W-1:0] r_onode, n_onode;
    logic [FIELD_W-1:0] r_onewp, n_onewp;
    logic             r_olast, n_olast;

    logic             w_acc;
    logic [CW-1:0]    w_cnt_ext, w_n_start;
    logic [CW-1:0]    w_ld_ext;
    logic [NW-1:0]    w_ld_idx;
    logic             w_ld_prio;
    logic [FIELD_W-1:0] w_from, w_to;
    logic [CW-1:0]    w_from_ext, w_to_ext;
    logic [NW-1:0]    w_to_idx;
    logic [NW-1:0]    w_v_idx;
    logic             w_in_run;
    logic             w_best_vld;
    logic [NW-1:0]    w_best_idx;
    logic [CW-1:0]    w_best_ext;
    logic [CW-1:0]    w_newp;
    logic             w_st_emit;
    logic [EW-1:0]    w_st_deg;
    logic [PRIO_W-1:0] w_scan_prio;
    logic             w_elig;
    logic             w_scan_clr;
    t_scan_ctl        w_scan_ctl;
    logic             w_pw_en;
    logic [NW-1:0]    w_pw_addr;
    logic [PRIO_W-1:0] w_pw_data;
    logic             w_sw_en;
    logic [NW-1:0]    w_sw_addr;
    logic [SW-1:0]    w_sw_data;
    logic [NW-1:0]    w_sr_addr;

    assign w_acc      = start && (r_state == S_IDLE);
    assign w_cnt_ext  = CW'(r_cnt);
    assign w_n_start  = (w_cnt_ext > CW'(MAX_NODES)) ? CW'(MAX_NODES) : w_cnt_ext;
    assign w_ld_ext   = CW'(i_node_index);
    assign w_ld_idx   = w_ld_ext[NW-1:0];
    assign w_ld_prio  = w_acc && (i_mode == MODE_PRIO) && (w_ld_ext < CW'(MAX_NODES));
    assign w_from     = r_edge_q[EDW-1:FIELD_W];
    assign w_to       = r_edge_q[FIELD_W-1:0];
    assign w_from_ext = CW'(w_from);
    assign w_to_ext   = CW'(w_to);
    assign w_to_idx   = w_to_ext[NW-1:0];
    assign w_v_idx    = r_v[NW-1:0];
    assign w_in_run   = (w_from_ext < r_n) && (w_to_ext < r_n);
    assign w_best_ext = CW'(w_best_idx);
    assign w_newp     = r_n - CW'(1) - r_pos;
    assign w_st_emit  = r_st_q[SW-1];
    assign w_st_deg   = r_st_q[EW-1:0];
    assign w_scan_prio = r_pvld_q ? r_prio_q : '0;
    assign w_elig     = !w_st_emit && (r_fb || (w_st_deg == '0));

    assign w_scan_ctl.clear  = w_scan_clr;
    assign w_scan_ctl.sample = (r_state == S_SCAN) && r_rd_vld && w_elig;

    ptopo_min_unit #(
        .NW (NW)
    ) u_min (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_scan_ctl),
        .i_idx   (r_rd_idx),
        .i_prio  (w_scan_prio),
        .o_vld   (w_best_vld),
        .o_idx   (w_best_idx)
    );

    // priority memory write port
    always_comb begin
        w_pw_en   = 1'b0;
        w_pw_addr = w_ld_idx;
        w_pw_data = i_priority_req;
        if (w_ld_prio) begin
            w_pw_en = 1'b1;
        end else if ((r_state == S_PICK) && w_best_vld) begin
            w_pw_en   = 1'b1;
            w_pw_addr = w_best_idx;
            w_pw_data = PRIO_W'(w_newp);
        end
    end

    // node state memory ports: {emitted, in-degree}
    assign w_sr_addr = (r_state == S_SCAN) ? w_v_idx : w_to_idx;

    always_comb begin
        w_sw_en   = 1'b0;
        w_sw_addr = w_to_idx;
        w_sw_data = '0;
        case (r_state)
            S_CLR: begin
                w_sw_en   = (r_v < r_n);
                w_sw_addr = w_v_idx;
            end
            S_IN_WR: begin
                w_sw_en   = 1'b1;
                w_sw_data = {w_st_emit, w_st_deg + EW'(1)};
            end
            S_PICK: begin
                w_sw_en   = w_best_vld;
                w_sw_addr = w_best_idx;
                w_sw_data = {1'b1, {EW{1'b0}}};
            end
            S_DEC_WR: begin
                w_sw_en   = (w_st_deg != '0);
                w_sw_data = {w_st_emit, w_st_deg - EW'(1)};
            end
            default: begin
                w_sw_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_pw_en) begin
            r_prio_mem[w_pw_addr] <= w_pw_data;
        end
        r_prio_q <= r_prio_mem[w_v_idx];
        r_pvld_q <= r_pvld[w_v_idx];
        if (w_sw_en) begin
            r_st_mem[w_sw_addr] <= w_sw_data;
        end
        r_st_q <= r_st_mem[w_sr_addr];
        if (w_acc && (i_mode == MODE_EDGE) && (r_etot < EW'(MAX_EDGES))) begin
            r_edge_mem[r_etot[EAW-1:0]] <= {i_edge_higher, i_edge_lower};
        end
        r_edge_q <= r_edge_mem[r_e[EAW-1:0]];
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_n        = r_n;
        n_v        = r_v;
        n_pos      = r_pos;
        n_e        = r_e;
        n_etot     = r_etot;
        n_fb       = r_fb;
        n_rd_vld   = r_rd_vld;
        n_rd_idx   = r_rd_idx;
        n_ovld     = 1'b0;
        n_onode    = r_onode;
        n_onewp    = r_onewp;
        n_olast    = r_olast;
        w_scan_clr = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_mode)
                        MODE_EDGE: begin
                            if (r_etot < EW'(MAX_EDGES)) begin
                                n_etot = r_etot + EW'(1);
                            end
                        end
                        MODE_RUN: begin
                            n_n   = w_n_start;
                            n_v   = '0;
                            n_pos = '0;
                            n_fb  = 1'b0;
                            n_state = (w_n_start == '0) ? S_DONE : S_CLR;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLR: begin
                if (r_v < r_n) begin
                    n_v = r_v + CW'(1);
                end else begin
                    n_e     = '0;
                    n_state = S_IN_RD;
                end
            end
            S_IN_RD: begin
                if (r_e < r_etot) begin
                    n_state = S_IN_ST;
                end else begin
                    n_v        = '0;
                    n_rd_vld   = 1'b0;
                    w_scan_clr = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_IN_ST: begin
                if (w_in_run) begin
                    n_state = S_IN_WR;
                end else begin
                    n_e     = r_e + EW'(1);
                    n_state = S_IN_RD;
                end
            end
            S_IN_WR: begin
                n_e     = r_e + EW'(1);
                n_state = S_IN_RD;
            end
            S_SCAN: begin
                if (r_v < r_n) begin
                    n_v      = r_v + CW'(1);
                    n_rd_vld = 1'b1;
                    n_rd_idx = w_v_idx;
                end else begin
                    n_rd_vld = 1'b0;
                    if (!r_rd_vld) begin
                        n_state = S_PICK;
                    end
                end
            end
            S_PICK: begin
                if (w_best_vld) begin
                    n_ovld  = 1'b1;
                    n_onode = w_best_ext[FIELD_W-1:0];
                    n_onewp = w_newp[FIELD_W-1:0];
                    n_olast = (r_pos == r_n - CW'(1));
                    if (r_fb) begin
                        n_state = S_NEXT;
                    end else begin
                        n_e     = '0;
                        n_state = S_DEC_RD;
                    end
                end else if (!r_fb) begin
                    // nothing ready: cycle, order the rest by priority alone
                    n_fb       = 1'b1;
                    n_v        = '0;
                    w_scan_clr = 1'b1;
                    n_state    = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DEC_RD: begin
                n_state = (r_e < r_etot) ? S_DEC_ST : S_NEXT;
            end
            S_DEC_ST: begin
                if ((w_from_ext == w_best_ext) && (w_to_ext < r_n)) begin
                    n_state = S_DEC_WR;
                end else begin
                    n_e     = r_e + EW'(1);
                    n_state = S_DEC_RD;
                end
            end
            S_DEC_WR: begin
                n_e     = r_e + EW'(1);
                n_state = S_DEC_RD;
            end
            S_NEXT: begin
                if (r_pos == r_n - CW'(1)) begin
                    n_state = S_DONE;
                end else begin
                    n_pos      = r_pos + CW'(1);
                    n_v        = '0;
                    w_scan_clr = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_DONE: begin
                n_etot  = '0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_n      <= '0;
            r_v      <= '0;
            r_pos    <= '0;
            r_e      <= '0;
            r_etot   <= '0;
            r_fb     <= 1'b0;
            r_rd_vld <= 1'b0;
            r_ovld   <= 1'b0;
            r_pvld   <= '0;
        end else begin
            r_state  <= n_state;
            r_n      <= n_n;
            r_v      <= n_v;
            r_pos    <= n_pos;
            r_e      <= n_e;
            r_etot   <= n_etot;
            r_fb     <= n_fb;
            r_rd_vld <= n_rd_vld;
            r_ovld   <= n_ovld;
            if (i_cfg_we) begin
                r_cnt <= i_cfg_wdata;
            end
            if (w_pw_en) begin
                r_pvld[w_pw_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= n_rd_idx;
        r_onode  <= n_onode;
        r_onewp  <= n_onewp;
        r_olast  <= n_olast;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_ovld;
    assign o_out_node     = r_onode;
    assign o_new_priority = r_onewp;
    assign o_last         = r_olast;

endmodule

FILE: hdl/ptopo_checker.sv
// Port-level checker for the topological ordering block, with its bind.
module ptopo_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic [ptopo_pkg::MODE_W-1:0]   i_mode,
    input logic                           o_valid,
    input logic [ptopo_pkg::FIELD_W-1:0]  o_new_priority,
    input logic                           o_last
);
    import ptopo_pkg::*;

    // results only come out of a run
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result item outside a run");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result item after the last one");

    a_last_prio_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_new_priority == '0))
        else $error("last item without priority zero");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_mode == MODE_RUN)) |=> busy)
        else $error("run item did not raise busy");

    a_load_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_mode != MODE_RUN)) |=> !busy)
        else $error("load item raised busy");

endmodule

bind priority_topological_order ptopo_checker u_ptopo_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_mode         (i_mode),
    .o_valid        (o_valid),
    .o_new_priority (o_new_priority),
    .o_last         (o_last)
);
